/* rtl/core/size_aware_lru_directory_top_macros.svh */
// assertion macros for the size-aware lru directory
// used by size_aware_lru_directory_top; needs aclk and aresetn in scope
`ifndef SIZE_AWARE_LRU_DIRECTORY_TOP_MACROS_SVH
`define SIZE_AWARE_LRU_DIRECTORY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SALRU_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("salru check failed");
`define SALRU_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("salru check failed");
`else
`define SALRU_ASSERT_NOW(lbl, a, b)
`define SALRU_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* rtl/core/salru_pkg.sv */
// shared types and constants of the size-aware lru directory
// no dependencies
`timescale 1ns / 1ps
package salru_pkg;
    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 24;
    localparam int ADDR_W  = 3;
    localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(65536);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_INSERTED = 3'd2,
        STAT_PRESENT  = 3'd3,
        STAT_TOOLARGE = 3'd4,
        STAT_CLEARED  = 3'd5,
        STAT_EVICTED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_EVICT,
        ST_STORE
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] item_size;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [KEY_W-1:0]  key_out;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] occupancy;
        logic              last;
    } result_t;
endpackage

/* rtl/core/salru_front.sv */
// front end: accepts request beats, drops unused commands, two-deep queue
// depends on salru_pkg
`timescale 1ns / 1ps
module salru_front import salru_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);
    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_item.cmd != CMD_NONE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

/* rtl/core/salru_back.sv */
// back end: tag table, recency ranks, byte count, eviction loop, result register
// depends on salru_pkg
`timescale 1ns / 1ps
module salru_back import salru_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    input  logic [SIZE_W-1:0] capacity,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);
    state_t              state_reg, state_next;
    item_t               cur_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_W-1:0]    key_reg  [ENTRIES];
    logic [SIZE_W-1:0]   size_reg [ENTRIES];
    logic [SLOT_W-1:0]   rank_reg [ENTRIES];
    logic [CNT_W-1:0]    cnt_reg;
    logic [SIZE_W-1:0]   occ_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic [ENTRIES-1:0]  match;
    logic                any_match;
    logic [SLOT_W-1:0]   match_slot, old_slot, free_slot;
    logic                out_free, too_large, need_evict;
    logic [SIZE_W:0]     sum;
    logic [SIZE_W-1:0]   occ_evict, occ_store;
    logic [CNT_W-1:0]    cnt_m1;

    logic                emit, do_touch, do_clear, do_evict, do_store;
    result_t             res_next;

    always_comb begin
        match_slot = '0;
        old_slot   = '0;
        free_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
            if (match[i]) begin
                match_slot = SLOT_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == '0)) begin
                old_slot = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign any_match  = |match;
    assign out_free   = !out_valid_reg || out_ready;
    assign too_large  = cur_reg.item_size > capacity;
    assign sum        = {1'b0, occ_reg} + {1'b0, cur_reg.item_size};
    // evict while over budget or every slot taken, unless table is empty
    assign need_evict = (cnt_reg != '0) &&
                        ((cnt_reg == CNT_W'(ENTRIES)) || (sum > {1'b0, capacity}));
    assign occ_evict  = (occ_reg >= size_reg[old_slot]) ? occ_reg - size_reg[old_slot] : '0;
    assign occ_store  = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
    assign cnt_m1     = cnt_reg - CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) state_next = ST_MATCH;
            end
            ST_MATCH: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (cur_reg.cmd == CMD_INSERT && !hit_reg && !too_large) begin
                    state_next = ST_EVICT;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVICT: begin
                if (!need_evict) state_next = ST_STORE;
            end
            ST_STORE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        emit     = 1'b0;
        do_touch = 1'b0;
        do_clear = 1'b0;
        do_evict = 1'b0;
        do_store = 1'b0;
        res_next = '{status: STAT_MISS, key_out: cur_reg.key, slot: '0,
                     occupancy: occ_reg, last: 1'b1};
        unique case (state_reg)
            ST_IDLE:  q_pop = q_valid;
            ST_MATCH: ;
            ST_DECIDE: begin
                if (out_free) begin
                    case (cur_reg.cmd)
                        CMD_LOOKUP: begin
                            emit     = 1'b1;
                            do_touch = hit_reg;
                            if (hit_reg) begin
                                res_next.status = STAT_HIT;
                                res_next.slot   = hit_slot_reg;
                            end
                        end
                        CMD_CLEAR: begin
                            emit               = 1'b1;
                            do_clear           = 1'b1;
                            res_next.status    = STAT_CLEARED;
                            res_next.occupancy = '0;
                        end
                        CMD_INSERT: begin
                            if (hit_reg) begin
                                emit            = 1'b1;
                                res_next.status = STAT_PRESENT;
                            end else if (too_large) begin
                                emit            = 1'b1;
                                res_next.status = STAT_TOOLARGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVICT: begin
                if (need_evict && out_free) begin
                    emit               = 1'b1;
                    do_evict           = 1'b1;
                    res_next.status    = STAT_EVICTED;
                    res_next.key_out   = key_reg[old_slot];
                    res_next.slot      = old_slot;
                    res_next.occupancy = occ_evict;
                    res_next.last      = 1'b0;
                end
            end
            ST_STORE: begin
                if (out_free) begin
                    emit               = 1'b1;
                    do_store           = 1'b1;
                    res_next.status    = STAT_INSERTED;
                    res_next.slot      = free_slot;
                    res_next.occupancy = occ_store;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_touch) begin
                // younger entries slide down, the hit becomes newest
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && SLOT_W'(i) != hit_slot_reg &&
                        rank_reg[i] > rank_reg[hit_slot_reg]) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
                rank_reg[hit_slot_reg] <= cnt_m1[SLOT_W-1:0];
            end
            if (do_clear) begin
                valid_reg <= '0;
                cnt_reg   <= '0;
                occ_reg   <= '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    rank_reg[i] <= '0;
                end
            end
            if (do_evict) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && SLOT_W'(i) != old_slot && rank_reg[i] != '0) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
                valid_reg[old_slot] <= 1'b0;
                rank_reg[old_slot]  <= '0;
                cnt_reg             <= cnt_m1;
                occ_reg             <= occ_evict;
            end
            if (do_store) begin
                valid_reg[free_slot] <= 1'b1;
                rank_reg[free_slot]  <= cnt_reg[SLOT_W-1:0];
                cnt_reg              <= cnt_reg + CNT_W'(1);
                occ_reg              <= occ_store;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (state_reg == ST_MATCH) begin
            hit_reg      <= any_match;
            hit_slot_reg <= match_slot;
        end
        if (emit) begin
            out_reg <= res_next;
        end
        if (do_store) begin
            key_reg[free_slot]  <= cur_reg.key;
            size_reg[free_slot] <= cur_reg.item_size;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
endmodule

/* rtl/core/size_aware_lru_directory_top.sv */
// Size-aware lru directory of 16 slots under a programmable byte budget
// (capacity_bytes at address 0, reset 65536). A lookup or clear passes from
// the front queue through the idle, match and decide states to its result;
// an insert that misses and fits goes on through the evict and store states,
// set by the back end's sequencer that evicts the oldest entry one beat at a
// time. A two-deep request queue and a result register let the input side
// keep accepting while results wait. Command 3 is dropped without a result.
// depends on salru_pkg, salru_front, salru_back and the assertion macro header
`timescale 1ns / 1ps
`include "size_aware_lru_directory_top_macros.svh"
module size_aware_lru_directory_top import salru_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [SIZE_W-1:0] s_item_size,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [KEY_W-1:0]  m_key_out,
    output logic [SLOT_W-1:0] m_slot,
    output logic [SIZE_W-1:0] m_occupancy,
    output logic              m_last
);
    logic [SIZE_W-1:0] capacity_reg;
    item_t             in_item, q_item;
    logic              q_valid, q_pop;
    result_t           res;
    logic              no_slot_beat;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == 1'b0) ? 32'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr[ADDR_W-1] == 1'b0) begin
            capacity_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign in_item = '{cmd: cmd_t'(s_cmd), key: s_key, item_size: s_item_size};

    salru_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    salru_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .capacity  (capacity_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_status    = res.status;
    assign m_key_out   = res.key_out;
    assign m_slot      = res.slot;
    assign m_occupancy = res.occupancy;
    assign m_last      = res.last;

    assign no_slot_beat = m_valid && (m_status == STAT_MISS || m_status == STAT_PRESENT ||
                                      m_status == STAT_TOOLARGE || m_status == STAT_CLEARED);

    `SALRU_ASSERT_NOW(a_evict_not_last, m_valid && m_status == STAT_EVICTED, !m_last)
    `SALRU_ASSERT_NOW(a_clear_empty, m_valid && m_status == STAT_CLEARED, m_occupancy == '0)
    `SALRU_ASSERT_NOW(a_no_slot, no_slot_beat, m_slot == '0)
    `SALRU_ASSERT_NEXT(a_pop_match, q_pop, !q_pop)
endmodule
